/* design/tprp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touchpad pointer mapper package
// Shared types, command and result codes, register map and configuration
// bundle for the touchpad region to pointer mapper.
// ----------------------------------------------------------------------------
package tprp_pkg;

    localparam int SLOT_COUNT = 20;
    localparam int SLOT_W     = (SLOT_COUNT > 2) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [15:0] SLOT_LIMIT = 16'(SLOT_COUNT);

    typedef enum logic [3:0] {
        CMD_SYNC  = 4'd0,
        CMD_LEFT  = 4'd1,
        CMD_TOOL2 = 4'd2,
        CMD_TOOL3 = 4'd3,
        CMD_TOOL4 = 4'd4,
        CMD_TOOL5 = 4'd5,
        CMD_SLOT  = 4'd6,
        CMD_POSX  = 4'd7,
        CMD_POSY  = 4'd8,
        CMD_OTHER = 4'd9
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_LEFT  = 2'd0,
        KIND_RIGHT = 2'd1,
        KIND_MOVE  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        REG_X_AXIS_MIN    = 3'd0,
        REG_Y_AXIS_MIN    = 3'd1,
        REG_ACCEPT_X_LOW  = 3'd2,
        REG_ACCEPT_X_HIGH = 3'd3,
        REG_ACCEPT_Y_LOW  = 3'd4,
        REG_ACCEPT_Y_HIGH = 3'd5,
        REG_X_SCALE       = 3'd6,
        REG_Y_SCALE       = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [15:0] x_axis_min;
        logic signed [15:0] y_axis_min;
        logic [15:0]        accept_x_low;
        logic [15:0]        accept_x_high;
        logic [15:0]        accept_y_low;
        logic [15:0]        accept_y_high;
        logic [23:0]        x_scale;
        logic [23:0]        y_scale;
    } cfg_t;

    // All results of one event: optional button word, then optional move word
    typedef struct packed {
        logic               btn_valid;
        kind_t              btn_kind;
        logic               btn_down;
        logic               mv_valid;
        logic signed [15:0] move_dx;
        logic signed [15:0] move_dy;
    } evt_t;

endpackage

/* design/tprp_apb_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touchpad pointer mapper configuration registers
// APB-style register bank: zero-wait writes and combinational read-back.
// ----------------------------------------------------------------------------
module tprp_apb_regs
    import tprp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.x_axis_min    <= 16'sd0;
            cfg_reg.y_axis_min    <= 16'sd0;
            cfg_reg.accept_x_low  <= 16'd0;
            cfg_reg.accept_x_high <= 16'hFFFF;
            cfg_reg.accept_y_low  <= 16'd0;
            cfg_reg.accept_y_high <= 16'hFFFF;
            cfg_reg.x_scale       <= 24'h010000;
            cfg_reg.y_scale       <= 24'h010000;
        end else if (wr_en) begin
            unique case (idx)
                REG_X_AXIS_MIN:    cfg_reg.x_axis_min    <= pwdata[15:0];
                REG_Y_AXIS_MIN:    cfg_reg.y_axis_min    <= pwdata[15:0];
                REG_ACCEPT_X_LOW:  cfg_reg.accept_x_low  <= pwdata[15:0];
                REG_ACCEPT_X_HIGH: cfg_reg.accept_x_high <= pwdata[15:0];
                REG_ACCEPT_Y_LOW:  cfg_reg.accept_y_low  <= pwdata[15:0];
                REG_ACCEPT_Y_HIGH: cfg_reg.accept_y_high <= pwdata[15:0];
                REG_X_SCALE:       cfg_reg.x_scale       <= pwdata[23:0];
                REG_Y_SCALE:       cfg_reg.y_scale       <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_X_AXIS_MIN:    prdata = {{16{cfg_reg.x_axis_min[15]}}, cfg_reg.x_axis_min};
            REG_Y_AXIS_MIN:    prdata = {{16{cfg_reg.y_axis_min[15]}}, cfg_reg.y_axis_min};
            REG_ACCEPT_X_LOW:  prdata = {16'd0, cfg_reg.accept_x_low};
            REG_ACCEPT_X_HIGH: prdata = {16'd0, cfg_reg.accept_x_high};
            REG_ACCEPT_Y_LOW:  prdata = {16'd0, cfg_reg.accept_y_low};
            REG_ACCEPT_Y_HIGH: prdata = {16'd0, cfg_reg.accept_y_high};
            REG_X_SCALE:       prdata = {8'd0, cfg_reg.x_scale};
            REG_Y_SCALE:       prdata = {8'd0, cfg_reg.y_scale};
            default:           prdata = 32'd0;
        endcase
    end

endmodule

/* design/tprp_axis.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touchpad pointer mapper axis unit
// Scales one axis offset to a Q16.16 screen point and splits the step plus
// residue into an integer move, truncated toward zero, and a new residue.
// ----------------------------------------------------------------------------
module tprp_axis
    import tprp_pkg::*;
(
    input  logic [15:0]        touch,
    input  logic [15:0]        low,
    input  logic [23:0]        scale,
    input  logic [31:0]        prev_pt,
    input  logic signed [17:0] residue,
    output logic [31:0]        point,
    output logic signed [17:0] residue_new,
    output logic signed [15:0] move
);

    logic [15:0] span;
    logic [39:0] prod;
    logic [33:0] acc;
    logic [17:0] floor_q;
    logic [17:0] ip;
    logic [15:0] frac;
    logic        neg_frac;

    assign span  = touch - low;
    assign prod  = {24'd0, span} * {16'd0, scale};
    assign point = (|prod[39:32]) ? 32'hFFFF_FFFF : prod[31:0];

    assign acc      = {{16{residue[17]}}, residue} + {2'b00, point} - {2'b00, prev_pt};
    assign floor_q  = acc[33:16];
    assign frac     = acc[15:0];
    assign neg_frac = acc[33] && (|frac);

    assign ip          = neg_frac ? (floor_q + 18'd1) : floor_q;
    assign residue_new = neg_frac ? {2'b11, frac} : {2'b00, frac};

    always_comb begin
        if ((ip[17:15] == 3'b000) || (ip[17:15] == 3'b111)) begin
            move = ip[15:0];
        end else if (ip[17]) begin
            move = 16'sh8000;
        end else begin
            move = 16'sh7FFF;
        end
    end

endmodule

/* design/tprp_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touchpad pointer mapper event core
// Input word register, touch and click state, and the combinational update
// that turns one event into its button and move results.
// ----------------------------------------------------------------------------
module tprp_core
    import tprp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic [3:0]  s_tuser,
    input  logic        can_push,
    output logic        push,
    output evt_t        evt
);

    logic               in_valid_reg;
    logic [3:0]         cmd_reg;
    logic signed [15:0] value_reg;

    logic [SLOT_W-1:0]  slot_reg,   slot_next;
    logic [15:0]        tx_reg,     tx_next;
    logic [15:0]        ty_reg,     ty_next;
    logic [2:0]         fc_reg,     fc_next;
    logic               click_reg,  click_next;
    logic [31:0]        prev_x_reg, prev_y_reg;
    logic signed [17:0] res_x_reg,  res_y_reg;

    logic [31:0]        pt_x, pt_y;
    logic signed [17:0] res_x_new, res_y_new;
    logic signed [15:0] mv_x, mv_y;
    logic               consume;
    logic               val_nz;
    logic               in_rect;
    logic               btn_valid;
    kind_t              btn_kind;

    function automatic logic [15:0] rel_coord(logic [15:0] raw, logic [15:0] mn);
        logic [16:0] d;
        d = {raw[15], raw} - {mn[15], mn};
        return d[16] ? 16'd0 : d[15:0];
    endfunction

    assign consume  = in_valid_reg && can_push;
    assign s_tready = !in_valid_reg || consume;
    assign val_nz   = |value_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            cmd_reg   <= s_tuser;
            value_reg <= s_tdata;
        end
    end

    always_comb begin
        slot_next  = slot_reg;
        tx_next    = tx_reg;
        ty_next    = ty_reg;
        fc_next    = fc_reg;
        click_next = click_reg;
        btn_valid  = 1'b0;
        btn_kind   = KIND_LEFT;
        unique case (cmd_reg) inside
            CMD_LEFT: begin
                if (val_nz != click_reg) begin
                    click_next = val_nz;
                    if (fc_reg == 3'd1) begin
                        btn_valid = 1'b1;
                        btn_kind  = KIND_LEFT;
                    end else if (fc_reg == 3'd2) begin
                        btn_valid = 1'b1;
                        btn_kind  = KIND_RIGHT;
                    end
                end
            end
            CMD_TOOL2, CMD_TOOL3, CMD_TOOL4, CMD_TOOL5: begin
                fc_next = val_nz ? cmd_reg[2:0] : 3'd1;
            end
            CMD_SLOT: begin
                if (!value_reg[15] && ($unsigned(value_reg) < SLOT_LIMIT)) begin
                    slot_next = value_reg[SLOT_W-1:0];
                end
            end
            CMD_POSX: begin
                if (slot_reg == '0) begin
                    tx_next = rel_coord(value_reg, cfg.x_axis_min);
                end
            end
            CMD_POSY: begin
                if (slot_reg == '0) begin
                    ty_next = rel_coord(value_reg, cfg.y_axis_min);
                end
            end
            default: ;
        endcase
    end

    assign in_rect = (tx_next >= cfg.accept_x_low) && (tx_next <= cfg.accept_x_high) &&
                     (ty_next >= cfg.accept_y_low) && (ty_next <= cfg.accept_y_high);

    tprp_axis u_axis_x (
        .touch       (tx_next),
        .low         (cfg.accept_x_low),
        .scale       (cfg.x_scale),
        .prev_pt     (prev_x_reg),
        .residue     (res_x_reg),
        .point       (pt_x),
        .residue_new (res_x_new),
        .move        (mv_x)
    );

    tprp_axis u_axis_y (
        .touch       (ty_next),
        .low         (cfg.accept_y_low),
        .scale       (cfg.y_scale),
        .prev_pt     (prev_y_reg),
        .residue     (res_y_reg),
        .point       (pt_y),
        .residue_new (res_y_new),
        .move        (mv_y)
    );

    assign evt.btn_valid = btn_valid;
    assign evt.btn_kind  = btn_kind;
    assign evt.btn_down  = val_nz;
    assign evt.mv_valid  = in_rect;
    assign evt.move_dx   = mv_x;
    assign evt.move_dy   = mv_y;
    assign push          = consume && (btn_valid || in_rect);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg   <= '0;
            tx_reg     <= 16'd0;
            ty_reg     <= 16'd0;
            fc_reg     <= 3'd1;
            click_reg  <= 1'b0;
            prev_x_reg <= 32'd0;
            prev_y_reg <= 32'd0;
            res_x_reg  <= 18'sd0;
            res_y_reg  <= 18'sd0;
        end else if (consume) begin
            slot_reg  <= slot_next;
            tx_reg    <= tx_next;
            ty_reg    <= ty_next;
            fc_reg    <= fc_next;
            click_reg <= click_next;
            if (in_rect) begin
                prev_x_reg <= pt_x;
                prev_y_reg <= pt_y;
                res_x_reg  <= res_x_new;
                res_y_reg  <= res_y_new;
            end
        end
    end

`ifndef SYNTHESIS
    a_fc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (fc_reg >= 3'd1) && (fc_reg <= 3'd5))
        else $error("finger count out of range");

    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {{(16-SLOT_W){1'b0}}, slot_reg} < SLOT_LIMIT)
        else $error("slot register out of range");

    a_residue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_x_reg <= 18'sd65535) && (res_x_reg >= -18'sd65535) &&
        (res_y_reg <= 18'sd65535) && (res_y_reg >= -18'sd65535))
        else $error("residue reached a whole pixel");
`endif

endmodule

/* design/tprp_out_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touchpad pointer mapper result queue
// Two-entry queue of event results; serializes the button word and the
// move word of each entry onto the result channel.
// ----------------------------------------------------------------------------
module tprp_out_queue
    import tprp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  evt_t        evt,
    output logic        can_push,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);

    evt_t       q_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       phase_reg;
    evt_t       head;
    logic       show_btn;
    logic       pop_word;
    logic       pop_entry;

    assign head      = q_reg[rd_ptr_reg];
    assign show_btn  = head.btn_valid && !phase_reg;
    assign m_tvalid  = (count_reg != 2'd0);
    assign m_tuser   = show_btn ? head.btn_kind : KIND_MOVE;
    assign m_tdata   = show_btn ? {39'd0, head.btn_down}
                                : {7'd0, head.move_dy, head.move_dx, 1'b0};
    assign m_tlast   = !show_btn || !head.mv_valid;
    assign pop_word  = m_tvalid && m_tready;
    assign pop_entry = pop_word && m_tlast;
    assign can_push  = (count_reg != 2'd2) || pop_entry;

    always_comb begin
        count_next = count_reg;
        if (push && !pop_entry) begin
            count_next = count_reg + 2'd1;
        end else if (!push && pop_entry) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
            phase_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop_entry) begin
                rd_ptr_reg <= !rd_ptr_reg;
                phase_reg  <= 1'b0;
            end else if (pop_word) begin
                phase_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= evt;
        end
    end

`ifndef SYNTHESIS
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 2'd2)
        else $error("result queue overfilled");

    a_head_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (head.btn_valid || head.mv_valid))
        else $error("queued entry holds no result");
`endif

endmodule

/* design/touchpad_region_to_pointer_mapper_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touchpad region to pointer mapper
// Turns multitouch events into button and relative move results.
//
//   Channel   Dir  Ports                              Payload
//   event     in   s_tvalid/s_tready/s_tdata/s_tuser  value, cmd
//   result    out  m_tvalid/m_tready/m_tdata/m_tuser  kind, button, dx, dy, last
//   config    in   psel/penable/pwrite/paddr/pwdata   8 registers at 4*i
//
// One event is taken per cycle while s_tready is high; its results leave one
// word per cycle while m_tready is high, passing through the input register and
// the result queue. An event with a button and a move result sends two words.
// Reset is synchronous, active low, and needs no clearing pass.
// A stalled result channel fills the two-entry result queue, then the input
// register, then drops s_tready.
// ----------------------------------------------------------------------------
module touchpad_region_to_pointer_mapper_top
    import tprp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] value
    input  logic [3:0]  s_tuser,   // [3:0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [0] button_down, [16:1] move_dx, [32:17] move_dy
    output logic [1:0]  m_tuser,   // [1:0] result_kind
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t cfg;
    evt_t evt;
    logic push;
    logic can_push;

    tprp_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tprp_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .can_push (can_push),
        .push     (push),
        .evt      (evt)
    );

    tprp_out_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .evt      (evt),
        .can_push (can_push),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
